### hw/rtl/gdd_pkg.sv
// gdd_pkg: shared types, constants and calendar tables for the date difference block
// no dependencies; used by gdd_day_count and gregorian_date_difference
package gdd_pkg;

  localparam int unsigned DATE_MAX_YEAR = 9999;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 23;
  localparam int STAT_W  = 2;
  localparam int LIMIT_W = 17;
  localparam int QUOT_W  = 8;
  localparam int MSTART_W = 9;

  // floor(x / 100) = (x * 5243) >> 19 for every 14-bit x
  localparam int DIV100_MUL_W = 13;
  localparam int DIV100_SHIFT = 19;
  localparam int PROD_W       = YEAR_W + DIV100_MUL_W;
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_FIRST_BAD  = 2'd1,
    ST_SECOND_BAD = 2'd2,
    ST_EARLIER    = 2'd3
  } status_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  typedef struct packed {
    logic               valid;
    logic               ok;
    logic [COUNT_W-1:0] count;
  } count_t;

  // days before the month in a common year
  function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [MSTART_W-1:0] s;
    case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // month length in a common year
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] n;
    case (m)
      4'd2:    n = 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

### hw/rtl/gdd_day_count.sv
// gdd_day_count: three-stage pipeline that checks one date and maps it to a day count
// depends on gdd_pkg
module gdd_day_count
  import gdd_pkg::*;
#(
  parameter int unsigned MAX_YEAR = DATE_MAX_YEAR
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  date_t  in_date,
  output count_t out_cnt
);

  localparam logic [LIMIT_W-1:0] YearLimit = LIMIT_W'(MAX_YEAR);

  // stage a: year / 100 and (year - 1) / 100
  logic               a_valid_r;
  date_t              a_date_r;
  logic [YEAR_W-1:0]  a_past_r;
  logic [QUOT_W-1:0]  a_qy_r;
  logic [QUOT_W-1:0]  a_qp_r;
  logic [YEAR_W-1:0]  a_past_nxt;
  logic [PROD_W-1:0]  a_prod_y;
  logic [PROD_W-1:0]  a_prod_p;

  assign a_past_nxt = in_date.year - YEAR_W'(1);
  assign a_prod_y   = PROD_W'(in_date.year) * PROD_W'(DIV100_MUL);
  assign a_prod_p   = PROD_W'(a_past_nxt) * PROD_W'(DIV100_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
    end
    a_date_r <= in_date;
    a_past_r <= a_past_nxt;
    a_qy_r   <= a_prod_y[DIV100_SHIFT +: QUOT_W];
    a_qp_r   <= a_prod_p[DIV100_SHIFT +: QUOT_W];
  end

  // stage b: leap rule, validity, month offset, 365 per past year
  logic               b_valid_r;
  logic               b_ok_r;
  logic [COUNT_W-1:0] b_p365_r;
  logic [MSTART_W:0]  b_part_r;
  logic [YEAR_W-3:0]  b_p4_r;
  logic [QUOT_W-1:0]  b_qp_r;
  logic [YEAR_W-1:0]  b_rem;
  logic               b_leap;
  logic               b_year_ok;
  logic               b_month_ok;
  logic [DAY_W-1:0]   b_len;
  logic               b_ok_nxt;
  logic [MSTART_W:0]  b_part_nxt;

  always_comb begin
    b_rem      = a_date_r.year - YEAR_W'(a_qy_r) * YEAR_W'(100);
    b_leap     = ((a_date_r.year[1:0] == 2'b00) && (b_rem != '0)) ||
                 ((b_rem == '0) && (a_qy_r[1:0] == 2'b00));
    b_year_ok  = (a_date_r.year != '0) && (LIMIT_W'(a_date_r.year) <= YearLimit);
    b_month_ok = (a_date_r.month >= MONTH_JAN) && (a_date_r.month <= MONTH_DEC);
    b_len      = ((a_date_r.month == MONTH_FEB) && b_leap) ? 5'd29
                                                           : month_len(a_date_r.month);
    b_ok_nxt   = b_year_ok && b_month_ok && (a_date_r.day != '0) &&
                 (a_date_r.day <= b_len);
    b_part_nxt = (MSTART_W+1)'(a_date_r.day) +
                 (MSTART_W+1)'(month_start(a_date_r.month)) +
                 (MSTART_W+1)'((a_date_r.month > MONTH_FEB) && b_leap);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
    b_ok_r   <= b_ok_nxt;
    b_p365_r <= COUNT_W'(a_past_r) * COUNT_W'(365);
    b_part_r <= b_part_nxt;
    b_p4_r   <= a_past_r[YEAR_W-1:2];
    b_qp_r   <= a_qp_r;
  end

  // stage c: sum of the terms
  logic               c_valid_r;
  logic               c_ok_r;
  logic [COUNT_W-1:0] c_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
    c_ok_r    <= b_ok_r;
    c_count_r <= b_p365_r + COUNT_W'(b_part_r) + COUNT_W'(b_p4_r) -
                 COUNT_W'(b_qp_r) + COUNT_W'(b_qp_r[QUOT_W-1:2]);
  end

  assign out_cnt.valid = c_valid_r;
  assign out_cnt.ok    = c_ok_r;
  assign out_cnt.count = c_count_r;

endmodule

### hw/rtl/gregorian_date_difference.sv
// throughput: one date pair per cycle; busy stays low, the pipeline never stalls
// the depth is set by the day count pipeline (three stages) plus the subtract stage
// reset: synchronous, active low; clears only the valid bits, so pairs in flight at reset are dropped
// gregorian_date_difference: top level, two day count pipelines and the compare stage
// depends on gdd_pkg and gdd_day_count
module gregorian_date_difference
  import gdd_pkg::*;
#(
  parameter int unsigned MAX_YEAR = DATE_MAX_YEAR
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [DAY_W-1:0]          in_first_day,
  input  logic [MONTH_W-1:0]        in_first_month,
  input  logic [YEAR_W-1:0]         in_first_year,
  input  logic [DAY_W-1:0]          in_second_day,
  input  logic [MONTH_W-1:0]        in_second_month,
  input  logic [YEAR_W-1:0]         in_second_year,
  output logic                      out_valid,
  output logic [STAT_W-1:0]         out_status,
  output logic signed [COUNT_W-1:0] out_day_difference
);

  logic   beat_in;
  date_t  date_a;
  date_t  date_b;
  count_t cnt_a;
  count_t cnt_b;

  assign busy    = 1'b0;
  assign beat_in = start && !busy;

  assign date_a = '{day: in_first_day, month: in_first_month, year: in_first_year};
  assign date_b = '{day: in_second_day, month: in_second_month, year: in_second_year};

  gdd_day_count #(
    .MAX_YEAR(MAX_YEAR)
  ) u_count_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(beat_in),
    .in_date (date_a),
    .out_cnt (cnt_a)
  );

  gdd_day_count #(
    .MAX_YEAR(MAX_YEAR)
  ) u_count_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(beat_in),
    .in_date (date_b),
    .out_cnt (cnt_b)
  );

  logic               valid_r;
  status_t            status_r;
  logic [COUNT_W-1:0] diff_r;
  status_t            status_nxt;
  logic [COUNT_W-1:0] diff_nxt;

  always_comb begin
    if (!cnt_a.ok) begin
      status_nxt = ST_FIRST_BAD;
      diff_nxt   = '0;
    end else if (!cnt_b.ok) begin
      status_nxt = ST_SECOND_BAD;
      diff_nxt   = '0;
    end else begin
      status_nxt = (cnt_b.count < cnt_a.count) ? ST_EARLIER : ST_OK;
      diff_nxt   = cnt_b.count - cnt_a.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cnt_a.valid;
    end
    status_r <= status_nxt;
    diff_r   <= diff_nxt;
  end

  assign out_valid          = valid_r;
  assign out_status         = status_r;
  assign out_day_difference = diff_r;

`ifndef NO_ASSERTIONS
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_a.valid == cnt_b.valid)
    else $error("day count lanes out of step");

  a_out_from_lane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cnt_a.valid))
    else $error("result beat without a counted date pair");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status_r == ST_FIRST_BAD || status_r == ST_SECOND_BAD)
      |-> diff_r == '0)
    else $error("invalid date with nonzero difference");

  a_earlier_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status_r == ST_EARLIER) |-> diff_r != '0)
    else $error("earlier status with zero difference");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for gregorian_date_difference, predicts status and day gap per pair
// depends on gdd_pkg and the gregorian_date_difference rtl
module tb_top;
  import gdd_pkg::*;

  localparam int unsigned YEAR_LIMIT = DATE_MAX_YEAR;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    status_t                    status;
    logic signed [COUNT_W-1:0]  gap;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [DAY_W-1:0]   in_first_day, in_second_day;
  logic [MONTH_W-1:0] in_first_month, in_second_month;
  logic [YEAR_W-1:0]  in_first_year, in_second_year;
  logic out_valid;
  logic [STAT_W-1:0] out_status;
  logic signed [COUNT_W-1:0] out_day_difference;

  outcome_t pending_results[$];
  int idle_pct;
  int pairs_sent;
  int results_checked;
  int mismatches;
  int quiet_cycles;
  int status_seen[4];
  int unsigned days_before[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  int unsigned days_in[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  gregorian_date_difference #(
    .MAX_YEAR(YEAR_LIMIT)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_first_day      (in_first_day),
    .in_first_month    (in_first_month),
    .in_first_year     (in_first_year),
    .in_second_day     (in_second_day),
    .in_second_month   (in_second_month),
    .in_second_year    (in_second_year),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_day_difference(out_day_difference)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic date_t mk(input int unsigned d, input int unsigned m, input int unsigned y);
    date_t r;
    r.day = DAY_W'(d);
    r.month = MONTH_W'(m);
    r.year = YEAR_W'(y);
    return r;
  endfunction

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    if (m == MONTH_FEB && is_leap(y)) begin
      return 29;
    end
    return days_in[m - 1];
  endfunction

  function automatic bit date_valid(input date_t dt);
    if (dt.year < 1 || dt.year > YEAR_LIMIT || dt.month < MONTH_JAN || dt.month > MONTH_DEC) begin
      return 1'b0;
    end
    return dt.day >= 1 && dt.day <= month_days(dt.month, dt.year);
  endfunction

  function automatic int unsigned day_serial(input date_t dt);
    int unsigned p;
    int unsigned n;
    p = dt.year - 1;
    n = dt.day + days_before[dt.month - 1];
    if (dt.month > MONTH_FEB && is_leap(dt.year)) begin
      n = n + 1;
    end
    return n + p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic outcome_t date_gap(input date_t a, input date_t b);
    outcome_t r;
    int unsigned na;
    int unsigned nb;
    r.status = ST_OK;
    r.gap = '0;
    if (!date_valid(a)) begin
      r.status = ST_FIRST_BAD;
    end else if (!date_valid(b)) begin
      r.status = ST_SECOND_BAD;
    end else begin
      na = day_serial(a);
      nb = day_serial(b);
      r.gap = COUNT_W'(nb - na);
      if (nb < na) begin
        r.status = ST_EARLIER;
      end
    end
    return r;
  endfunction

  function automatic int unsigned rand_year();
    case ($urandom_range(9))
      0: return $urandom_range(5, 1);
      1: return $urandom_range(YEAR_LIMIT, YEAR_LIMIT - 4);
      2: return 100 * $urandom_range(99, 1);
      3: return 4 * $urandom_range(YEAR_LIMIT / 4, 1);
      default: return $urandom_range(YEAR_LIMIT, 1);
    endcase
  endfunction

  function automatic date_t rand_date();
    int unsigned y;
    int unsigned m;
    y = rand_year();
    m = $urandom_range(MONTH_DEC, MONTH_JAN);
    return mk($urandom_range(month_days(m, y), 1), m, y);
  endfunction

  // valid date with one field pushed out of range, or plain noise; a day of 31 may then get month december
  function automatic date_t broken_date();
    date_t r;
    r = rand_date();
    case ($urandom_range(5))
      0: r.day = '0;
      1: r.day = DAY_W'($urandom_range(31, month_days(r.month, r.year) + 1));
      2: r.month = ($urandom_range(1) == 0) ? '0 : MONTH_W'($urandom_range(15, 13));
      3: r.year = ($urandom_range(1) == 0) ? '0 :
                  YEAR_W'($urandom_range(16383, YEAR_LIMIT + 1));
      default: r = date_t'($urandom);
    endcase
    if (r.day == 31 && $urandom_range(3) == 0) begin
      r.month = MONTH_DEC;
    end
    return r;
  endfunction

  task automatic send_pair(input date_t a, input date_t b);
    @(negedge clk);
    start <= 1'b1;
    in_first_day <= a.day;
    in_first_month <= a.month;
    in_first_year <= a.year;
    in_second_day <= b.day;
    in_second_month <= b.month;
    in_second_year <= b.year;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic test_directed();
    send_pair(mk(1, 1, 1), mk(1, 1, 1));
    send_pair(mk(1, 1, 1), mk(31, 12, YEAR_LIMIT));
    send_pair(mk(31, 12, YEAR_LIMIT), mk(1, 1, 1));
    send_pair(mk(0, 1, 2000), mk(1, 1, 2000));
    send_pair(mk(0, 0, 0), mk(31, 15, 16383));
    send_pair(mk(1, 1, 2000), mk(1, 13, 2000));
    send_pair(mk(1, 0, 2000), mk(1, 1, 2000));
    send_pair(mk(1, 15, 2000), mk(1, 1, 2000));
    send_pair(mk(1, 1, 0), mk(1, 1, 2000));
    send_pair(mk(1, 1, 2000), mk(1, 1, YEAR_LIMIT + 1));
    send_pair(mk(1, 1, 2000), mk(31, 12, 16383));
    send_pair(mk(31, 1, 2000), mk(31, 3, 2000));
    send_pair(mk(29, 2, 2000), mk(1, 3, 2000));
    send_pair(mk(29, 2, 1900), mk(1, 3, 1900));
    send_pair(mk(28, 2, 2024), mk(29, 2, 2024));
    send_pair(mk(1, 1, 2023), mk(29, 2, 2023));
    send_pair(mk(30, 4, 2010), mk(31, 4, 2010));
    send_pair(mk(28, 2, 1900), mk(1, 3, 1900));
    send_pair(mk(31, 12, 1999), mk(1, 1, 2000));
    send_pair(mk(15, 6, 8191), mk(15, 6, 8192));
    send_pair(mk(1, 3, 400), mk(28, 2, 400));
    send_pair(mk(0, 0, 0), mk(0, 0, 0));
    send_pair(mk(30, 2, 2000), mk(1, 1, 1));
  endtask

  task automatic test_valid_pairs(input int n);
    date_t a;
    date_t b;
    repeat (n) begin
      a = rand_date();
      b = rand_date();
      case ($urandom_range(5))
        0: b = a;
        1: b.year = a.year;
        2: b = mk($urandom_range(month_days(a.month, a.year), 1), a.month, a.year);
        default: ;
      endcase
      send_pair(a, b);
    end
  endtask

  // month ends around february in century years and in multiples of four
  task automatic test_leap_edges(input int n);
    date_t a;
    date_t b;
    int unsigned y;
    repeat (n) begin
      y = ($urandom_range(1) == 0) ? 100 * $urandom_range(99, 1) : 4 * $urandom_range(2499, 1);
      a = mk($urandom_range(30, 27), MONTH_FEB, y);
      b = mk($urandom_range(2, 1), 3, y + $urandom_range(1));
      if ($urandom_range(1) == 0) begin
        send_pair(a, b);
      end else begin
        send_pair(b, a);
      end
    end
  endtask

  task automatic test_malformed(input int n);
    repeat (n) begin
      case ($urandom_range(2))
        0: send_pair(broken_date(), rand_date());
        1: send_pair(rand_date(), broken_date());
        default: send_pair(broken_date(), broken_date());
      endcase
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    date_t fa;
    date_t fb;
    quiet_cycles = quiet_cycles + 1;
    if (rst_n) begin
      if (start && !busy) begin
        fa = mk(in_first_day, in_first_month, in_first_year);
        fb = mk(in_second_day, in_second_month, in_second_year);
        pending_results.push_back(date_gap(fa, fb));
        pairs_sent = pairs_sent + 1;
        quiet_cycles = 0;
      end
      if (out_valid) begin
        quiet_cycles = 0;
        if (pending_results.size() == 0) begin
          $error("result beat with no pair outstanding: status %0d day_difference %0d",
                 out_status, out_day_difference);
          mismatches = mismatches + 1;
        end else begin
          want = pending_results.pop_front();
          results_checked = results_checked + 1;
          status_seen[want.status] = status_seen[want.status] + 1;
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            mismatches = mismatches + 1;
          end
          if (out_day_difference !== want.gap) begin
            $error("day_difference: expected %0d, actual %0d",
                   $signed(want.gap), out_day_difference);
            mismatches = mismatches + 1;
          end
        end
      end
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_first_day = '0;
    in_first_month = '0;
    in_first_year = '0;
    in_second_day = '0;
    in_second_month = '0;
    in_second_year = '0;
    idle_pct = 0;
    pairs_sent = 0;
    results_checked = 0;
    mismatches = 0;
    quiet_cycles = 0;
    status_seen = '{0, 0, 0, 0};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 38;
    test_directed();
    test_valid_pairs(400);
    test_leap_edges(100);
    test_malformed(100);
    idle_pct = 82;
    test_valid_pairs(400);
    test_leap_edges(100);
    test_malformed(100);
    idle_pct = 0;
    test_valid_pairs(400);
    test_leap_edges(100);
    test_malformed(100);

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d date pairs sent, %0d results checked, sender idling 38%%, 82%%, then none",
             pairs_sent, results_checked);
    $display("status mix: ok %0d, first bad %0d, second bad %0d, second earlier %0d",
             status_seen[ST_OK], status_seen[ST_FIRST_BAD], status_seen[ST_SECOND_BAD],
             status_seen[ST_EARLIER]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
